### sv/kpb_pkg.sv
// ----------------------------------------------------------------------------
// kpb_pkg
// Shared types, widths, register indexes and helpers for the brightness
// control loop (scalar Kalman filter followed by a PID drive controller).
// ----------------------------------------------------------------------------
`default_nettype none

package kpb_pkg;

  // Default values for the top-level parameters.
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int DRIVE_MAX_DEF   = 1000;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register widths.
  localparam int SETPOINT_W = 12;
  localparam int QN_W       = 24;
  localparam int RN_W       = 32;
  localparam int GAIN_W     = 21;
  localparam int IDRV_W     = 10;

  // Result field widths.
  localparam int DRV_OUT_W = 10;
  localparam int FILT_W    = 12;
  localparam int CERR_W    = 13;

  // Datapath widths.
  localparam int FRAC_BITS = 16;
  localparam int VAR_W     = 40;               // error variance, unsigned Q24.16
  localparam int DIV_W     = VAR_W + 1;        // gain denominator
  localparam int K_W       = FRAC_BITS + 1;    // gain, 0..65536
  localparam int VAR_SPLIT = 20;               // variance split for the multiplier
  localparam int MUL_W     = 22;               // signed operand width
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = 60;
  localparam int PID_W     = ACC_W - FRAC_BITS;
  localparam int ESUM_W    = 16;
  localparam int ESUM_MAX  = 32767;
  localparam int ESUM_MIN  = -32768;

  // Register reset values.
  localparam int SETPOINT_RST = 2048;
  localparam int QN_RST       = 131072;
  localparam int RN_RST       = 262144;
  localparam int GAIN_P_RST   = 6554;
  localparam int GAIN_I_RST   = 66;
  localparam int GAIN_D_RST   = -6554;
  localparam int IDRV_RST     = 500;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT   = 3'd0,
    REG_PROC_NOISE = 3'd1,
    REG_MEAS_NOISE = 3'd2,
    REG_GAIN_P     = 3'd3,
    REG_GAIN_I     = 3'd4,
    REG_GAIN_D     = 3'd5,
    REG_INIT_DRIVE = 3'd6
  } reg_idx_t;

  // Current register contents used by the datapath.
  typedef struct packed {
    logic        [SETPOINT_W-1:0] setpoint;
    logic        [QN_W-1:0]       proc_noise;
    logic        [RN_W-1:0]       meas_noise;
    logic signed [GAIN_W-1:0]     gain_p;
    logic signed [GAIN_W-1:0]     gain_i;
    logic signed [GAIN_W-1:0]     gain_d;
  } cfg_t;

  // State reloads caused by a register write, valid in the write cycle.
  typedef struct packed {
    logic                  ld_est;
    logic [SETPOINT_W-1:0] est_val;
    logic                  ld_var;
    logic [VAR_W-1:0]      var_val;
    logic                  ld_drive;
    logic [IDRV_W-1:0]     drive_val;
  } reload_t;

  // Divider status.
  typedef struct packed {
    logic           done;
    logic [K_W-1:0] quotient;
  } div_stat_t;

  // Accumulator operations of the shared multiply-accumulate unit.
  typedef enum logic [2:0] {
    MAC_HOLD,
    MAC_CLEAR,
    MAC_LOAD,
    MAC_ADD,
    MAC_ADD_HI
  } mac_op_t;

  typedef struct packed {
    logic    mul_en;
    mac_op_t op;
  } mac_ctl_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_PRED,
    S_DEN,
    S_DIVGO,
    S_DIV,
    S_MEST,
    S_AEST,
    S_MVLO,
    S_AVLO,
    S_MVHI,
    S_AVHI,
    S_ERR,
    S_MP,
    S_AP,
    S_MD,
    S_AD,
    S_MI,
    S_AI,
    S_PID,
    S_DRV
  } state_t;

  // Clamp a signed drive value to 1..dmax.
  function automatic logic [16:0] clamp_drive(input logic signed [PID_W:0] v,
                                              input int unsigned dmax);
    logic signed [PID_W:0] hi;
    logic        [16:0]    res;
    hi = (PID_W + 1)'(dmax);
    if (v < (PID_W + 1)'(1)) begin
      res = 17'd1;
    end else if (v > hi) begin
      res = 17'(dmax);
    end else begin
      res = 17'(v);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### sv/kpb_in_if.sv
// ----------------------------------------------------------------------------
// kpb_in_if
// Sample channel: one light-sensor reading per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface kpb_in_if #(
  parameter int SAMPLE_BITS = kpb_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

`default_nettype wire

### sv/kpb_out_if.sv
// ----------------------------------------------------------------------------
// kpb_out_if
// Result channel: drive level, filtered value and control error per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface kpb_out_if;
  logic                                valid;
  logic                                ready;
  logic        [kpb_pkg::DRV_OUT_W-1:0] drive_level;
  logic        [kpb_pkg::FILT_W-1:0]    filtered_value;
  logic signed [kpb_pkg::CERR_W-1:0]    control_error;

  modport source (output valid, output drive_level, output filtered_value,
                  output control_error, input ready);
  modport sink   (input valid, input drive_level, input filtered_value,
                  input control_error, output ready);
endinterface

`default_nettype wire

### sv/kalman_pid_brightness_loop_top.sv
// ----------------------------------------------------------------------------
// kalman_pid_brightness_loop_top
// Brightness control loop: scalar Kalman filter on each sensor sample, then
// a PID controller that updates a clamped drive level.
// ----------------------------------------------------------------------------
// Per sample, the Kalman gain comes from a serial divider that produces one
// quotient bit per cycle, and the six products of the update run one after
// the other through a single shared multiplier. The sample port is ready
// only while the sequencer is idle; a finished result sits in the output
// register, and while it waits the next sample is still accepted but stalls
// in S_DRV until the sink has taken the waiting result. Configuration writes
// take effect at once: writing the setpoint also loads the estimate, writing
// either noise register reloads the error variance with Q + R, and writing
// the initial drive reloads the drive level, clamped to 1..DRIVE_MAX.
// ----------------------------------------------------------------------------
`default_nettype none

module kalman_pid_brightness_loop_top #(
  parameter int SAMPLE_BITS = kpb_pkg::SAMPLE_BITS_DEF,
  parameter int DRIVE_MAX   = kpb_pkg::DRIVE_MAX_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [kpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kpb_pkg::CFG_DATA_W-1:0] cfg_data,
  kpb_in_if.sink                              sample_in,
  kpb_out_if.source                           result_out
);
  import kpb_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int DW   = $clog2(DRIVE_MAX + 1);
  localparam int XW   = (SB > SETPOINT_W) ? SB : SETPOINT_W;
  localparam int EW   = XW + 1;
  localparam int SUMW = ((EW > ESUM_W) ? EW : ESUM_W) + 1;

  state_t state, state_next;

  cfg_t      cfg;
  reload_t   reload;
  div_stat_t div_stat;
  mac_ctl_t  mac_ctl;
  logic      div_start;

  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;
  logic signed [ACC_W-1:0] mac_load;
  logic signed [ACC_W-1:0] acc;

  // Loop state.
  logic        [SB-1:0]     estimate;
  logic        [VAR_W-1:0]  error_variance;
  logic signed [EW-1:0]     previous_error;
  logic signed [ESUM_W-1:0] error_sum;
  logic        [DW-1:0]     current_drive;

  // Per-sample working registers.
  logic        [SB-1:0]    sample;
  logic        [VAR_W-1:0] pp;
  logic        [DIV_W-1:0] den;
  logic signed [EW-1:0]    err;
  logic signed [EW:0]      derr;
  logic signed [PID_W-1:0] pid;
  logic                    out_valid;

  // Combinational helpers.
  logic        [VAR_W:0]   pp_sum;
  logic signed [SB:0]      diff;
  logic        [K_W-1:0]   k_comp;
  logic signed [EW-1:0]    err_next;
  logic signed [EW:0]      derr_next;
  logic signed [SUMW-1:0]  esum_wide;
  logic signed [ESUM_W-1:0] esum_next;
  logic signed [ACC_W-1:0] pid_round;
  logic signed [PID_W:0]   drive_sum;
  logic        [DW-1:0]    drive_new;
  logic        [DW-1:0]    drive_reload;
  logic                    out_free;

  kpb_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .reload    (reload)
  );

  kpb_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (pp),
    .den   (den),
    .stat  (div_stat)
  );

  kpb_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mac_ctl),
    .a        (mul_a),
    .b        (mul_b),
    .load_val (mac_load),
    .acc      (acc)
  );

  // Arithmetic around the shared units.
  always_comb begin
    pp_sum    = (VAR_W + 1)'(error_variance) + (VAR_W + 1)'(cfg.proc_noise);
    diff      = $signed({1'b0, sample}) - $signed({1'b0, estimate});
    k_comp    = K_W'(1 << FRAC_BITS) - div_stat.quotient;
    err_next  = $signed(EW'(estimate)) - $signed(EW'(cfg.setpoint));
    derr_next = (EW + 1)'(err_next) - (EW + 1)'(previous_error);
    esum_wide = SUMW'(error_sum) + SUMW'(err_next);
    if (esum_wide > SUMW'(ESUM_MAX)) begin
      esum_next = ESUM_W'(ESUM_MAX);
    end else if (esum_wide < SUMW'(ESUM_MIN)) begin
      esum_next = ESUM_W'(ESUM_MIN);
    end else begin
      esum_next = ESUM_W'(esum_wide);
    end
    // Truncation toward zero: bias negative sums before the shift.
    pid_round    = acc + (acc[ACC_W-1] ? ACC_W'((1 << FRAC_BITS) - 1) : ACC_W'(0));
    drive_sum    = (PID_W + 1)'(pid) + (PID_W + 1)'($signed({1'b0, current_drive}));
    drive_new    = DW'(clamp_drive(drive_sum, DRIVE_MAX));
    drive_reload = DW'(clamp_drive((PID_W + 1)'($signed({1'b0, reload.drive_val})),
                                   DRIVE_MAX));
    out_free     = !out_valid || result_out.ready;
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (sample_in.valid) state_next = S_PRED;
      S_PRED:  state_next = S_DEN;
      S_DEN:   state_next = S_DIVGO;
      S_DIVGO: state_next = S_DIV;
      S_DIV:   if (div_stat.done) state_next = S_MEST;
      S_MEST:  state_next = S_AEST;
      S_AEST:  state_next = S_MVLO;
      S_MVLO:  state_next = S_AVLO;
      S_AVLO:  state_next = S_MVHI;
      S_MVHI:  state_next = S_AVHI;
      S_AVHI:  state_next = S_ERR;
      S_ERR:   state_next = S_MP;
      S_MP:    state_next = S_AP;
      S_AP:    state_next = S_MD;
      S_MD:    state_next = S_AD;
      S_AD:    state_next = S_MI;
      S_MI:    state_next = S_AI;
      S_AI:    state_next = S_PID;
      S_PID:   state_next = S_DRV;
      S_DRV:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: operand selection and unit control.
  always_comb begin
    sample_in.ready = 1'b0;
    div_start       = 1'b0;
    mac_ctl.mul_en  = 1'b0;
    mac_ctl.op      = MAC_HOLD;
    mul_a           = '0;
    mul_b           = '0;
    mac_load        = ACC_W'({estimate, {FRAC_BITS{1'b0}}});
    unique case (state)
      S_IDLE:  sample_in.ready = !rst;
      S_DIVGO: div_start = 1'b1;
      S_MEST: begin
        mac_ctl.mul_en = 1'b1;
        mac_ctl.op     = MAC_LOAD;
        mul_a          = MUL_W'($signed({1'b0, div_stat.quotient}));
        mul_b          = MUL_W'(diff);
      end
      S_MVLO: begin
        mac_ctl.mul_en = 1'b1;
        mac_ctl.op     = MAC_CLEAR;
        mul_a          = MUL_W'($signed({1'b0, k_comp}));
        mul_b          = MUL_W'($signed({1'b0, pp[VAR_SPLIT-1:0]}));
      end
      S_MVHI: begin
        mac_ctl.mul_en = 1'b1;
        mul_a          = MUL_W'($signed({1'b0, k_comp}));
        mul_b          = MUL_W'($signed({1'b0, pp[VAR_W-1:VAR_SPLIT]}));
      end
      S_ERR:   mac_ctl.op = MAC_CLEAR;
      S_MP: begin
        mac_ctl.mul_en = 1'b1;
        mul_a          = MUL_W'(cfg.gain_p);
        mul_b          = MUL_W'(err);
      end
      S_MD: begin
        mac_ctl.mul_en = 1'b1;
        mul_a          = MUL_W'(cfg.gain_d);
        mul_b          = MUL_W'(derr);
      end
      S_MI: begin
        mac_ctl.mul_en = 1'b1;
        mul_a          = MUL_W'(cfg.gain_i);
        mul_b          = MUL_W'(error_sum);
      end
      S_AEST, S_AVLO, S_AP, S_AD, S_AI: mac_ctl.op = MAC_ADD;
      S_AVHI:  mac_ctl.op = MAC_ADD_HI;
      default: begin
        // Remaining states use neither unit.
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Loop state, with reloads from register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      estimate       <= SB'(SETPOINT_RST);
      error_variance <= VAR_W'(QN_RST + RN_RST);
      previous_error <= '0;
      error_sum      <= '0;
      current_drive  <= DW'(clamp_drive((PID_W + 1)'(IDRV_RST), DRIVE_MAX));
    end else begin
      if (reload.ld_est) begin
        estimate <= SB'(reload.est_val);
      end else if (state == S_MVLO) begin
        estimate <= acc[ACC_W-1] ? '0 : acc[FRAC_BITS +: SB];
      end
      if (reload.ld_var) begin
        error_variance <= reload.var_val;
      end else if (state == S_ERR) begin
        error_variance <= acc[FRAC_BITS +: VAR_W];
      end
      if (state == S_ERR) begin
        previous_error <= err_next;
        error_sum      <= esum_next;
      end
      if (reload.ld_drive) begin
        current_drive <= drive_reload;
      end else if (state == S_DRV && out_free) begin
        current_drive <= drive_new;
      end
    end
  end

  // Per-sample working registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && sample_in.valid) begin
      sample <= sample_in.adc_sample;
    end
    if (state == S_PRED) begin
      // Predicted variance saturates at the top of its range.
      pp <= pp_sum[VAR_W] ? {VAR_W{1'b1}} : pp_sum[VAR_W-1:0];
    end
    if (state == S_DEN) begin
      den <= DIV_W'(pp) + DIV_W'(cfg.meas_noise);
    end
    if (state == S_ERR) begin
      err  <= err_next;
      derr <= derr_next;
    end
    if (state == S_PID) begin
      pid <= pid_round[ACC_W-1:FRAC_BITS];
    end
  end

  // Output register: holds the result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DRV && out_free) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DRV && out_free) begin
      result_out.drive_level    <= DRV_OUT_W'(drive_new);
      result_out.filtered_value <= FILT_W'(estimate);
      result_out.control_error  <= CERR_W'(err);
    end
  end

  assign result_out.valid = out_valid;

endmodule

`default_nettype wire

### sv/kpb_cfg_regs.sv
// ----------------------------------------------------------------------------
// kpb_cfg_regs
// Configuration register file with the state reloads that a write triggers.
// ----------------------------------------------------------------------------
`default_nettype none

module kpb_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [kpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kpb_pkg::CFG_DATA_W-1:0] cfg_data,
  output kpb_pkg::cfg_t                       cfg,
  output kpb_pkg::reload_t                    reload
);
  import kpb_pkg::*;

  cfg_t cfg_next;

  // Register write decode.
  always_comb begin
    cfg_next = cfg;
    reload   = '0;
    if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SETPOINT: begin
          cfg_next.setpoint = cfg_data[SETPOINT_W-1:0];
          reload.ld_est     = 1'b1;
          reload.est_val    = cfg_data[SETPOINT_W-1:0];
        end
        REG_PROC_NOISE: begin
          cfg_next.proc_noise = cfg_data[QN_W-1:0];
          reload.ld_var       = 1'b1;
          reload.var_val      = VAR_W'(cfg_data[QN_W-1:0]) + VAR_W'(cfg.meas_noise);
        end
        REG_MEAS_NOISE: begin
          cfg_next.meas_noise = cfg_data[RN_W-1:0];
          reload.ld_var       = 1'b1;
          reload.var_val      = VAR_W'(cfg.proc_noise) + VAR_W'(cfg_data[RN_W-1:0]);
        end
        REG_GAIN_P: cfg_next.gain_p = $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_I: cfg_next.gain_i = $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_D: cfg_next.gain_d = $signed(cfg_data[GAIN_W-1:0]);
        REG_INIT_DRIVE: begin
          reload.ld_drive  = 1'b1;
          reload.drive_val = cfg_data[IDRV_W-1:0];
        end
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  // Register storage.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint   <= SETPOINT_W'(SETPOINT_RST);
      cfg.proc_noise <= QN_W'(QN_RST);
      cfg.meas_noise <= RN_W'(RN_RST);
      cfg.gain_p     <= GAIN_W'(GAIN_P_RST);
      cfg.gain_i     <= GAIN_W'(GAIN_I_RST);
      cfg.gain_d     <= GAIN_W'(GAIN_D_RST);
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

`default_nettype wire

### sv/kpb_divider.sv
// ----------------------------------------------------------------------------
// kpb_divider
// Restoring serial divider for the Kalman gain floor(num * 2^16 / den).
// Expects num <= den; one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kpb_divider (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [kpb_pkg::VAR_W-1:0] num,
  input  wire logic [kpb_pkg::DIV_W-1:0] den,
  output kpb_pkg::div_stat_t             stat
);
  import kpb_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic [DIV_W-1:0] rem;
  logic [K_W-1:0]   quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DIV_W:0]   rem_dbl;
  logic             fits;
  logic [DIV_W:0]   num_ext;

  // One shift-and-subtract step.
  always_comb begin
    rem_dbl = {rem, 1'b0};
    fits    = rem_dbl >= (DIV_W + 1)'(den);
    num_ext = (DIV_W + 1)'(num);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // A zero denominator gives a zero gain right away.
        busy <= (den != '0);
        done <= (den == '0);
        cnt  <= CNT_W'(FRAC_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      if (den == '0) begin
        quo <= '0;
        rem <= '0;
      end else if (num_ext >= (DIV_W + 1)'(den)) begin
        quo <= K_W'(1);
        rem <= DIV_W'(num_ext - (DIV_W + 1)'(den));
      end else begin
        quo <= '0;
        rem <= DIV_W'(num);
      end
    end else if (busy) begin
      quo <= {quo[K_W-2:0], fits};
      rem <= fits ? DIV_W'(rem_dbl - (DIV_W + 1)'(den)) : DIV_W'(rem_dbl);
    end
  end

  assign stat.done     = done;
  assign stat.quotient = quo;

endmodule

`default_nettype wire

### sv/kpb_mac.sv
// ----------------------------------------------------------------------------
// kpb_mac
// Shared signed multiplier with a registered product and an accumulator.
// Every product of the loop (estimate update, variance, PID terms) runs here.
// ----------------------------------------------------------------------------
`default_nettype none

module kpb_mac (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire kpb_pkg::mac_ctl_t                ctl,
  input  wire logic signed [kpb_pkg::MUL_W-1:0] a,
  input  wire logic signed [kpb_pkg::MUL_W-1:0] b,
  input  wire logic signed [kpb_pkg::ACC_W-1:0] load_val,
  output logic signed [kpb_pkg::ACC_W-1:0]      acc
);
  import kpb_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_ext = ACC_W'(prod);

  // Product register.
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= a * b;
    end
  end

  // Accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else begin
      unique case (ctl.op)
        MAC_HOLD:   acc <= acc;
        MAC_CLEAR:  acc <= '0;
        MAC_LOAD:   acc <= load_val;
        MAC_ADD:    acc <= acc + prod_ext;
        MAC_ADD_HI: acc <= acc + (prod_ext <<< VAR_SPLIT);
        default:    acc <= acc;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/kpb_checker.sv
// ----------------------------------------------------------------------------
// kpb_checker
// Port-level checks for the brightness control loop, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kpb_checker #(
  parameter int DRIVE_MAX = kpb_pkg::DRIVE_MAX_DEF
) (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic        [kpb_pkg::DRV_OUT_W-1:0] drive_level,
  input wire logic        [kpb_pkg::FILT_W-1:0]    filtered_value,
  input wire logic signed [kpb_pkg::CERR_W-1:0]    control_error
);

  // A stalled result keeps its payload until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive_level)
      && $stable(filtered_value) && $stable(control_error))
    else $error("result changed while stalled");

  // The drive level lies inside its clamp range; checked only while DRIVE_MAX fits the 10-bit field.
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (DRIVE_MAX > 1023) || (drive_level >= 1 && drive_level <= DRIVE_MAX))
    else $error("drive level out of range");

  // After a sample transfer the block is busy and no result appears at once.
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready && !$rose(out_valid))
    else $error("sample accepted while busy or result too early");

endmodule

bind kalman_pid_brightness_loop_top kpb_checker #(
  .DRIVE_MAX (DRIVE_MAX)
) u_kpb_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (sample_in.valid),
  .in_ready       (sample_in.ready),
  .out_valid      (result_out.valid),
  .out_ready      (result_out.ready),
  .drive_level    (result_out.drive_level),
  .filtered_value (result_out.filtered_value),
  .control_error  (result_out.control_error)
);

`default_nettype wire
